### rtl/core/address_allow_list_table_core_defines.svh
// Assertion helpers shared by the RTL of the allow list table.
// Every check is clocked on clk_i and is off while rst_ni is low.
`ifndef ADDRESS_ALLOW_LIST_TABLE_CORE_DEFINES_SVH
`define ADDRESS_ALLOW_LIST_TABLE_CORE_DEFINES_SVH

// Checks a property in every cycle.
`define AALT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define AALT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/aalt_pkg.sv
`default_nettype none

package aalt_pkg;

  localparam int CAPACITY     = 16;
  localparam int ADDRESS_BITS = 64;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream words.
  localparam int IDX_W       = 4;
  localparam int ADDR_PORT_W = 64;
  localparam int COUNT_OUT_W = 5;
  localparam int REQ_W       = 2;
  localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam int S_TDATA_W  = 72;
  localparam int M_FIELDS_W = 2 + 1 + COUNT_OUT_W + ADDR_PORT_W + 1;
  localparam int M_TDATA_W  = 80;
  localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_REMOVE,
    REQ_LOOKUP,
    REQ_READ
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_FULL,
    STATUS_NOT_FOUND
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_MOVE,
    ST_DONE
  } state_e;

  typedef struct packed {
    status_e                  status;
    logic                     found;
    logic [ADDR_PORT_W-1:0]   entry_address;
    logic                     entry_valid;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/aalt_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module aalt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/address_allow_list_table_core.sv
`default_nettype none
// Allow list of device addresses with room for CAPACITY entries, held in a
// small RAM. Each input word carries a request kind in tuser (add, remove,
// lookup or read an entry) and an address plus entry index in tdata; each
// request gives exactly one result word. Add appends an address that is not
// yet present, or reports full; remove finds the address, moves the last
// entry into its slot and shrinks the count, or reports not found; lookup
// tells presence; read returns the entry at an index below the count. The
// table is empty after reset and needs no clearing pass. Requests are
// handled one at a time: a read loads its result from a single RAM read,
// while add, remove and lookup search the current entries, since the search
// walks the RAM one slot per cycle through its single read port and one
// shared address comparator. The input side is ready again as soon as the
// result sits in the output register, so a new request can be taken while
// the previous result waits for the downstream side.

`include "address_allow_list_table_core_defines.svh"

module address_allow_list_table_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // [63:0] address, [67:64] entry_index, [71:68] zero
  input  wire logic [aalt_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] req_type
  input  wire logic [aalt_pkg::REQ_W-1:0]     s_axis_tuser_i,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [1:0] status, [2] found, [7:3] entry_count_out, [71:8] entry_address,
  // [72] entry_valid, [79:73] zero
  output      logic [aalt_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import aalt_pkg::*;

  // Sequencer state and control registers.
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;      // next slot to issue to the RAM
  logic [SLOT_W-1:0] chk_q, chk_d;      // slot whose data is on the RAM output
  logic              chk_vld_q, chk_vld_d;
  logic              m_valid_q, m_valid_d;

  // Request and result payload.
  req_type_e               req_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [IDX_W-1:0]        idx_q;
  result_t                 res_q, res_d;
  logic [M_TDATA_W-1:0]    m_data_q, m_data_d;

  // RAM port signals.
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [ADDRESS_BITS-1:0] ram_wdata;
  logic [SLOT_W-1:0]       ram_raddr;
  logic [ADDRESS_BITS-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic hit;
  logic more;
  logic idx_ok;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // The shared comparator: RAM output against the requested address.
  assign hit  = chk_vld_q && (ram_rdata == addr_q);
  assign more = ptr_q < count_q;

  // A read is valid only below the count, which never exceeds the capacity.
  assign idx_ok = CMP_W'(idx_q) < CMP_W'(count_q);

  aalt_ram #(
    .WIDTH (ADDRESS_BITS),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = (req_type_e'(s_axis_tuser_i) == REQ_READ) ? ST_READ : ST_SCAN;
        end
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = (req_q == REQ_REMOVE) ? ST_MOVE : ST_DONE;
        end else if (!more) begin
          state_d = ST_DONE;
        end
      end
      ST_MOVE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = chk_q;
    ram_wdata       = ram_rdata;
    ram_raddr       = ptr_q[SLOT_W-1:0];
    count_d         = count_q;
    ptr_d           = ptr_q;
    chk_d           = chk_q;
    chk_vld_d       = chk_vld_q;
    res_d           = res_q;
    m_valid_d       = m_valid_q && !m_axis_tready_i;
    m_data_d        = m_data_q;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        // Start the read of the requested slot right away.
        ram_raddr       = SLOT_W'(s_axis_tdata_i[ADDR_PORT_W +: IDX_W]);
        ptr_d           = '0;
        chk_vld_d       = 1'b0;
      end
      ST_READ: begin
        res_d.status        = STATUS_OK;
        res_d.found         = 1'b0;
        res_d.entry_valid   = idx_ok;
        res_d.entry_address = idx_ok ? ADDR_PORT_W'(ram_rdata) : '0;
      end
      ST_SCAN: begin
        res_d.status        = STATUS_OK;
        res_d.entry_valid   = 1'b0;
        res_d.entry_address = '0;
        if (hit) begin
          res_d.found = 1'b1;
          // For a remove, fetch the last entry to fill the hole at chk_q.
          ram_raddr   = SLOT_W'(count_q - CNT_W'(1));
          chk_vld_d   = 1'b0;
        end else if (more) begin
          ram_raddr = ptr_q[SLOT_W-1:0];
          ptr_d     = ptr_q + CNT_W'(1);
          chk_d     = ptr_q[SLOT_W-1:0];
          chk_vld_d = 1'b1;
        end else begin
          res_d.found = 1'b0;
          chk_vld_d   = 1'b0;
          case (req_q)
            REQ_ADD: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                res_d.status = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[SLOT_W-1:0];
                ram_wdata = addr_q;
                count_d   = count_q + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              res_d.status = STATUS_NOT_FOUND;
            end
            default: begin
              res_d.status = STATUS_OK;
            end
          endcase
        end
      end
      ST_MOVE: begin
        // Writing the last entry over itself is harmless.
        ram_we    = 1'b1;
        ram_waddr = chk_q;
        ram_wdata = ram_rdata;
        count_d   = count_q - CNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {M_PAD_W'(0), res_q.entry_valid, res_q.entry_address,
                       COUNT_OUT_W'(count_q), res_q.found, res_q.status};
        end
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      chk_q     <= '0;
      chk_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      chk_q     <= chk_d;
      chk_vld_q <= chk_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q  <= req_type_e'(s_axis_tuser_i);
      addr_q <= s_axis_tdata_i[ADDRESS_BITS-1:0];
      idx_q  <= s_axis_tdata_i[ADDR_PORT_W +: IDX_W];
    end
    res_q    <= res_d;
    m_data_q <= m_data_d;
  end

  `AALT_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `AALT_ASSERT(a_ptr_bound, state_q != ST_SCAN || ptr_q <= count_q, "pointer beyond count")
  `AALT_ASSERT_NEXT(a_accept_busy, in_fire, state_q != ST_IDLE, "accept left idle")
  `AALT_ASSERT_NEXT(a_move_shrinks, state_q == ST_MOVE, count_q == $past(count_q) - CNT_W'(1), "no shrink")

endmodule

`default_nettype wire

### tb/sv/tb_address_allow_list_table_core.sv
`default_nettype none

module tb_address_allow_list_table_core;
  import aalt_pkg::*;

  // One request word as the stream carries it.
  typedef struct {
    req_type_e   kind;
    logic [63:0] addr;
    logic [3:0]  idx;
  } request_t;

  // One result word split into its fields.
  typedef struct {
    status_e     status;
    logic        found;
    logic [4:0]  count;
    logic [63:0] entry_addr;
    logic        entry_valid;
  } outcome_t;

  localparam int POOL_N   = 24;
  localparam int SEG_LEN  = 150;
  localparam int RANDOM_N = 1420;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0]     s_tuser = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  address_allow_list_table_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the allow list, advanced once per accepted request word.
  logic [63:0] shadow_slots [CAPACITY];
  int unsigned shadow_count = 0;

  request_t    request_q [$];
  outcome_t    outcome_q [$];
  request_t    cur_req;
  int          n_taken = 0;
  int          n_total = 0;
  int          errors = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic [63:0] addr_pool [POOL_N];

  // Applies one request to the shadow list and returns the result it gives.
  function automatic outcome_t apply_request(request_t r);
    outcome_t    o;
    int unsigned pos;
    o.status      = STATUS_OK;
    o.found       = 1'b0;
    o.entry_addr  = '0;
    o.entry_valid = 1'b0;
    if (r.kind == REQ_READ) begin
      if (r.idx < shadow_count) begin
        o.entry_addr  = shadow_slots[r.idx];
        o.entry_valid = 1'b1;
      end
    end else begin
      pos = CAPACITY;
      for (int i = 0; i < shadow_count; i++) begin
        if (pos == CAPACITY && shadow_slots[i] == r.addr) begin
          pos = i;
        end
      end
      o.found = (pos < CAPACITY);
      if (r.kind == REQ_ADD && !o.found) begin
        if (shadow_count >= CAPACITY) begin
          o.status = STATUS_FULL;
        end else begin
          shadow_slots[shadow_count] = r.addr;
          shadow_count++;
        end
      end else if (r.kind == REQ_REMOVE) begin
        if (!o.found) begin
          o.status = STATUS_NOT_FOUND;
        end else begin
          // The last entry fills the hole left by the removed one.
          shadow_slots[pos] = shadow_slots[shadow_count - 1];
          shadow_count--;
        end
      end
    end
    o.count = shadow_count[4:0];
    return o;
  endfunction

  // Idle rate in percent: the sender idles little while the receiver idles a
  // lot in the first third, the other way round in the second, and neither
  // idles in the last third.
  function automatic int idle_pct(bit sender);
    if (n_taken < n_total / 3) begin
      return sender ? 8 : 58;
    end else if (n_taken < (2 * n_total) / 3) begin
      return sender ? 58 : 8;
    end
    return 0;
  endfunction

  task automatic push_req(req_type_e kind, logic [63:0] addr, logic [3:0] idx);
    request_t r;
    r.kind = kind;
    r.addr = addr;
    r.idx  = idx;
    request_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s at %0t: got %h, expected %h", what, $realtime, got, want);
    errors++;
  endtask

  // Sender: records the request word taken at this edge, then offers the next.
  always @(posedge clk_i) begin : drive_blk
    bit offer_next;
    if (rst_ni) begin
      offer_next = !s_valid;
      if (s_valid && s_axis_tready_o) begin
        outcome_q.push_back(apply_request(cur_req));
        n_taken <= n_taken + 1;
        offer_next = 1'b1;
      end
      if (offer_next) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          cur_req = request_q.pop_front();
          s_valid <= 1'b1;
          s_tdata <= {4'b0, cur_req.idx, cur_req.addr};
          s_tuser <= cur_req.kind;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off of the receiver, so that the block backs up to its input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_taken >= 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Receiver: each result word is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_blk
    outcome_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result word", m_axis_tdata_o[71:8], '0);
      end else begin
        want = outcome_q.pop_front();
        if (m_axis_tdata_o[1:0] != want.status) begin
          report_mismatch("status", m_axis_tdata_o[1:0], want.status);
        end
        if (m_axis_tdata_o[2] != want.found) begin
          report_mismatch("found", m_axis_tdata_o[2], want.found);
        end
        if (m_axis_tdata_o[7:3] != want.count) begin
          report_mismatch("entry_count_out", m_axis_tdata_o[7:3], want.count);
        end
        if (m_axis_tdata_o[71:8] != want.entry_addr) begin
          report_mismatch("entry_address", m_axis_tdata_o[71:8], want.entry_addr);
        end
        if (m_axis_tdata_o[72] != want.entry_valid) begin
          report_mismatch("entry_valid", m_axis_tdata_o[72], want.entry_valid);
        end
      end
    end
  end

  initial begin
    int        pick;
    bit        filling;
    logic [63:0] a;
    req_type_e k;

    // The first sixteen pool entries are also what the directed part loads,
    // so the random part can take them out again.
    addr_pool[0] = '1;
    addr_pool[1] = 64'h8000_0000_0000_0000;
    addr_pool[2] = 64'h5555_5555_5555_5555;
    addr_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
    addr_pool[4] = 64'h0000_0000_0000_0001;
    for (int i = 5; i < POOL_N; i++) begin
      addr_pool[i] = {$urandom, $urandom};
    end

    // Requests against an empty list.
    push_req(REQ_READ, '0, 4'd0);
    push_req(REQ_LOOKUP, '0, 4'd0);
    push_req(REQ_REMOVE, '1, 4'd0);
    // Add, add again while present, then remove so the last entry moves down.
    push_req(REQ_ADD, '0, 4'd0);
    push_req(REQ_ADD, addr_pool[0], 4'd15);
    push_req(REQ_ADD, '0, 4'd0);
    push_req(REQ_LOOKUP, addr_pool[0], 4'd0);
    push_req(REQ_REMOVE, '0, 4'd0);
    push_req(REQ_READ, '0, 4'd0);
    // Fill to capacity, then try a new address and one already present.
    for (int i = 1; i < CAPACITY; i++) begin
      push_req(REQ_ADD, addr_pool[i], 4'(i));
    end
    push_req(REQ_ADD, {$urandom, $urandom}, 4'd0);
    push_req(REQ_ADD, addr_pool[0], 4'd0);
    push_req(REQ_READ, '1, 4'd15);
    push_req(REQ_REMOVE, addr_pool[7], 4'd0);

    // Random part: segments that lean toward filling or draining the list, so
    // that both the full and the empty ends are reached again and again.
    for (int n = 0; n < RANDOM_N; n++) begin
      filling = ((n / SEG_LEN) % 2) == 0;
      pick    = $urandom_range(99);
      if (pick < (filling ? 50 : 15)) begin
        k = REQ_ADD;
      end else if (pick < (filling ? 62 : 65)) begin
        k = REQ_REMOVE;
      end else if (pick < (filling ? 80 : 82)) begin
        k = REQ_LOOKUP;
      end else begin
        k = REQ_READ;
      end
      a = addr_pool[$urandom_range(POOL_N - 1)];
      // Unknown addresses only where they cannot clog the list.
      if ((k != REQ_ADD && $urandom_range(9) == 0) || k == REQ_READ) begin
        a = {$urandom, $urandom};
      end
      push_req(k, a, 4'($urandom_range(15)));
    end
    n_total = request_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_valid || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_address_allow_list_table_core OK");
    end else begin
      $display("tb_address_allow_list_table_core NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_address_allow_list_table_core NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
